// ===== hw/rtl/berp_pkg.sv =====
// package for the buffer event record parser
// holds transaction types, action and status codes, record layout constants
// no dependencies
package berp_pkg;

   // default number of buffers in the rotation
   localparam int NUM_BUFFERS_DEFAULT = 3;

   // record layout
   localparam int POS_W = 5;
   localparam logic [POS_W-1:0] PREFIX_LEN = 5'd9;
   localparam logic [POS_W-1:0] DIGIT_POS  = 5'd9;
   localparam logic [POS_W-1:0] L_POS      = 5'd10;
   localparam logic [POS_W-1:0] LAST_POS   = 5'd18;

   // ascii characters
   localparam logic [7:0] CHAR_ZERO = 8'h30;
   localparam logic [7:0] CHAR_NINE = 8'h39;
   localparam logic [7:0] CHAR_A    = 8'h61;
   localparam logic [7:0] CHAR_F    = 8'h66;
   localparam logic [7:0] CHAR_L    = 8'h4c;

   typedef enum logic [1:0] {
      ACT_RECORD = 2'd0,
      ACT_DATA   = 2'd1,
      ACT_START  = 2'd2
   } action_type;

   typedef enum logic [2:0] {
      ST_OK           = 3'd0,
      ST_NOT_EVENT    = 3'd1,
      ST_BAD_HEX      = 3'd2,
      ST_MISSING_L    = 3'd3,
      ST_OUT_OF_ORDER = 3'd4,
      ST_BAD_INDEX    = 3'd5
   } status_type;

   typedef struct packed {
      logic [1:0] action;
      logic [7:0] byte_value;
   } req_type;

   typedef struct packed {
      logic        record_done;
      logic [2:0]  record_status;
      logic [1:0]  event_buffer;
      logic [31:0] event_length;
      logic [31:0] compressed_total;
      logic [31:0] uncompressed_total;
      logic        error_latched;
   } rsp_type;

   // handshake between input stage and engine
   typedef struct packed {
      logic valid;
      logic advance;
   } stage_ctl_type;

   // expected prefix character at a record position below PREFIX_LEN
   function automatic logic [7:0] prefix_char(input logic [3:0] idx);
      logic [7:0] c;
      case (idx)
         4'd0:    c = 8'h44; // D
         4'd1:    c = 8'h4d; // M
         4'd2:    c = 8'h41; // A
         4'd3:    c = 8'h32; // 2
         4'd4:    c = 8'h44; // D
         4'd5:    c = 8'h44; // D
         4'd6:    c = 8'h52; // R
         4'd7:    c = 8'h2d; // -
         4'd8:    c = 8'h42; // B
         default: c = 8'h00;
      endcase
      return c;
   endfunction

endpackage

// ===== hw/rtl/berp_in_stage.sv =====
// input register stage of the buffer event record parser
// holds one accepted transaction until the engine can take it
// depends on berp_pkg
module berp_in_stage
   import berp_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  req_type       req_data,
   input  logic          advance,
   output stage_ctl_type ctl,
   output req_type       item
);

   logic    valid_ff, valid_in;
   req_type item_ff, item_in;

   // free when empty or when the held transaction moves on this cycle
   assign req_ready = !valid_ff || advance;

   // next state of the holding register
   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (req_ready) begin
         valid_in = req_valid;
         if (req_valid) begin
            item_in = req_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   assign ctl.valid   = valid_ff;
   assign ctl.advance = advance;
   assign item        = item_ff;

endmodule

// ===== hw/rtl/berp_engine.sv =====
// record parsing engine of the buffer event record parser
// holds the parse state and totals and forms the result of one transaction
// depends on berp_pkg
module berp_engine
   import berp_pkg::*;
#(
   parameter int NUM_BUFFERS = NUM_BUFFERS_DEFAULT
) (
   input  logic          clock,
   input  logic          reset,
   input  stage_ctl_type ctl,
   input  req_type       item,
   output rsp_type       result
);

   localparam int BUF_W = (NUM_BUFFERS > 1) ? $clog2(NUM_BUFFERS) : 1;
   localparam logic [BUF_W-1:0] LAST_BUF  = BUF_W'(NUM_BUFFERS - 1);
   localparam logic [7:0]       DIGIT_MAX = 8'(32'(CHAR_ZERO) + NUM_BUFFERS - 1);

   logic [POS_W-1:0] pos_ff, pos_in;
   status_type       status_ff, status_in;
   logic [BUF_W-1:0] parsed_ff, parsed_in;
   logic [31:0]      len_ff, len_in;
   logic [BUF_W-1:0] expected_ff, expected_in;
   logic [31:0]      comp_ff, comp_in;
   logic [31:0]      uncomp_ff, uncomp_in;
   logic             err_ff, err_in;

   logic             fire;
   logic [7:0]       b;
   status_type       st_base;
   logic [BUF_W-1:0] buf_base;
   logic [31:0]      len_base;
   logic [7:0]       digit8;
   logic [3:0]       nibble;
   logic             hex_ok;
   logic             last;
   logic [BUF_W+1:0] buf_ext;

   assign fire = ctl.valid && ctl.advance;
   assign b    = item.byte_value;

   // a record restarts its per-record state at byte one
   assign st_base  = (pos_ff == '0) ? ST_OK : status_ff;
   assign buf_base = (pos_ff == '0) ? '0 : parsed_ff;
   assign len_base = (pos_ff == '0) ? '0 : len_ff;
   assign last     = (pos_ff >= LAST_POS);
   assign digit8   = b - CHAR_ZERO;

   // hex digit decode
   always_comb begin
      hex_ok = 1'b1;
      nibble = b[3:0];
      if (b inside {[CHAR_ZERO:CHAR_NINE]}) begin
         nibble = b[3:0];
      end else if (b inside {[CHAR_A:CHAR_F]}) begin
         nibble = 4'(b[3:0] + 4'd9);
      end else begin
         hex_ok = 1'b0;
      end
   end

   // next state and result
   always_comb begin
      pos_in      = pos_ff;
      status_in   = status_ff;
      parsed_in   = parsed_ff;
      len_in      = len_ff;
      expected_in = expected_ff;
      comp_in     = comp_ff;
      uncomp_in   = uncomp_ff;
      err_in      = err_ff;
      buf_ext     = '0;

      result.record_done   = 1'b0;
      result.record_status = ST_OK;
      result.event_buffer  = 2'd0;
      result.event_length  = '0;

      case (action_type'(item.action))
         ACT_RECORD: begin
            status_in = st_base;
            parsed_in = buf_base;
            len_in    = len_base;
            // check this byte unless the record already failed
            if (st_base == ST_OK) begin
               if (pos_ff < PREFIX_LEN) begin
                  if (b != prefix_char(pos_ff[3:0])) begin
                     status_in = ST_NOT_EVENT;
                  end
               end else if (pos_ff == DIGIT_POS) begin
                  if (b < CHAR_ZERO || b > DIGIT_MAX) begin
                     status_in = ST_BAD_INDEX;
                  end else begin
                     parsed_in = digit8[BUF_W-1:0];
                     if (digit8[BUF_W-1:0] != expected_ff) begin
                        status_in = ST_OUT_OF_ORDER;
                     end
                  end
               end else if (pos_ff == L_POS) begin
                  if (b != CHAR_L) begin
                     status_in = ST_MISSING_L;
                  end
               end else if (!hex_ok) begin
                  status_in = ST_BAD_HEX;
               end else begin
                  len_in = {len_base[27:0], nibble};
               end
            end
            // buffer index widened so it can be cut to the two result bits
            buf_ext = {2'b00, parsed_in};
            // record end
            if (last) begin
               pos_in                = '0;
               result.record_done    = 1'b1;
               result.record_status  = status_in;
               result.event_buffer   = buf_ext[1:0];
               if (status_in == ST_OK) begin
                  result.event_length = len_in;
                  comp_in             = comp_ff + len_in;
                  expected_in         = (expected_ff == LAST_BUF) ? '0
                                        : BUF_W'(expected_ff + 1'b1);
               end else if (status_in != ST_NOT_EVENT) begin
                  err_in = 1'b1;
               end
            end else begin
               pos_in = POS_W'(pos_ff + 1'b1);
            end
         end
         ACT_DATA: begin
            uncomp_in = uncomp_ff + 32'(b[7:5]) + 32'd1;
         end
         ACT_START: begin
            comp_in     = '0;
            uncomp_in   = '0;
            expected_in = '0;
            pos_in      = '0;
            status_in   = ST_OK;
            parsed_in   = '0;
            len_in      = '0;
         end
         default: begin
         end
      endcase

      result.compressed_total   = comp_in;
      result.uncompressed_total = uncomp_in;
      result.error_latched      = err_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= '0;
         status_ff   <= ST_OK;
         parsed_ff   <= '0;
         len_ff      <= '0;
         expected_ff <= '0;
         comp_ff     <= '0;
         uncomp_ff   <= '0;
         err_ff      <= 1'b0;
      end else if (fire) begin
         pos_ff      <= pos_in;
         status_ff   <= status_in;
         parsed_ff   <= parsed_in;
         len_ff      <= len_in;
         expected_ff <= expected_in;
         comp_ff     <= comp_in;
         uncomp_ff   <= uncomp_in;
         err_ff      <= err_in;
      end
   end

endmodule

// ===== hw/rtl/buffer_event_record_parser_core.sv =====
// Buffer event record parser, top level.
// Input channel req_*: one byte per transaction, with an action code: record
// byte, compressed data byte or start of session. Records are 19 ascii bytes
// "DMA2DDR-B", a buffer digit, 'L' and eight lowercase hex digits.
// Result channel rsp_*: exactly one result per input transaction, in order,
// carrying record completion and status, the buffer and length of a finished
// record, both running totals and the latched error flag.
// An accepted transaction is held in the input register; its result is loaded
// into the result register once that register is empty or being drained.
// Throughput: one transaction per cycle while results are taken, set by the
// single pass of the parse logic between the input register and the result register.
// When the receiver stalls, the result register holds and the input register
// still takes one more transaction; req_ready drops only when both are full.
// Reset (synchronous, active high) clears parse state, totals, expected
// buffer, error flag and both valid flags.
// depends on berp_pkg, berp_in_stage, berp_engine
module buffer_event_record_parser_core
   import berp_pkg::*;
#(
   parameter int NUM_BUFFERS = NUM_BUFFERS_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   logic          advance;
   stage_ctl_type ctl;
   req_type       item;
   rsp_type       result;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_data_ff, rsp_data_in;

   // result register can load when empty or being drained
   assign advance = !rsp_valid_ff || rsp_ready;

   berp_in_stage u_in_stage (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .advance   (advance),
      .ctl       (ctl),
      .item      (item)
   );

   berp_engine #(
      .NUM_BUFFERS (NUM_BUFFERS)
   ) u_engine (
      .clock  (clock),
      .reset  (reset),
      .ctl    (ctl),
      .item   (item),
      .result (result)
   );

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (advance) begin
         rsp_valid_in = ctl.valid;
         if (ctl.valid) begin
            rsp_data_in = result;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== hw/rtl/berp_checker.sv =====
// port-level checks for the buffer event record parser
// bound to buffer_event_record_parser_core; depends on berp_pkg
module berp_checker
   import berp_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   logic seen_err_ff, seen_err_in;

   // remember that an error was reported on a delivered result
   assign seen_err_in = seen_err_ff || (rsp_valid && rsp_ready && rsp_data.error_latched);

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_err_ff <= 1'b0;
      end else begin
         seen_err_ff <= seen_err_in;
      end
   end

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   // nothing is reported right after reset
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // record fields are zero when no record finished
   a_no_record: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.record_done |->
         rsp_data.record_status == ST_OK && rsp_data.event_length == '0 &&
         rsp_data.event_buffer == '0)
      else $error("record fields set without a finished record");

   // a failed record carries no length
   a_fail_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.record_status != ST_OK |-> rsp_data.event_length == '0)
      else $error("length reported for a failed record");

   // the error flag never clears once reported
   a_err_sticky: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && seen_err_ff |-> rsp_data.error_latched)
      else $error("latched error cleared");

endmodule

bind buffer_event_record_parser_core berp_checker u_berp_checker (.*);
